@@ design/rars_pkg.sv @@
// shared constants and types for the range assign / range sum tree
package rars_pkg;

	localparam int LEAVES      = 1024;
	localparam int NODE_DEPTH  = 2 * LEAVES;
	localparam int NODE_AW     = $clog2(NODE_DEPTH);
	localparam int IDX_W       = $clog2(LEAVES);
	localparam int LEN_W       = 11;
	localparam int SPAN_W      = IDX_W + 1;
	localparam int VAL_W       = 32;
	localparam int SUM_W       = 48;
	localparam int PROD_W      = VAL_W + SPAN_W + 1;
	localparam int STACK_DEPTH = IDX_W + 1;
	localparam int SP_W        = $clog2(STACK_DEPTH + 1);
	localparam int TOP_W       = $clog2(STACK_DEPTH);

	localparam logic [NODE_AW-1:0] ROOT_NODE = NODE_AW'(1);

	localparam logic OP_ASSIGN = 1'b0;
	localparam logic OP_QUERY  = 1'b1;

	typedef struct packed {
		logic signed [SUM_W-1:0] sum;
		logic                    mark;
		logic signed [VAL_W-1:0] val;
	} node_t;

	typedef struct packed {
		logic [NODE_AW-1:0]      v;
		logic [IDX_W-1:0]        lo;
		logic [IDX_W-1:0]        hi;
		logic [IDX_W-1:0]        l;
		logic [IDX_W-1:0]        r;
		logic                    right;
		logic signed [SUM_W-1:0] acc;
	} frame_t;

endpackage

@@ design/rars_if.sv @@
// handshake channels: command words, result words and length writes
interface rars_cmd_if;
	logic                              valid;
	logic                              ready;
	logic                              operation;
	logic [rars_pkg::IDX_W-1:0]        range_low;
	logic [rars_pkg::IDX_W-1:0]        range_high;
	logic signed [rars_pkg::VAL_W-1:0] value;
	modport source (output valid, operation, range_low, range_high, value, input ready);
	modport sink (input valid, operation, range_low, range_high, value, output ready);
endinterface

interface rars_rsp_if;
	logic                              valid;
	logic                              ready;
	logic signed [rars_pkg::SUM_W-1:0] range_sum;
	logic                              range_error;
	modport source (output valid, range_sum, range_error, input ready);
	modport sink (input valid, range_sum, range_error, output ready);
endinterface

interface rars_cfg_if;
	logic                       valid;
	logic                       ready;
	logic [rars_pkg::LEN_W-1:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

@@ design/rars_ram.sv @@
// generic single write port ram with registered read
module rars_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ design/range_assign_range_sum_tree_unit.sv @@
// top level: lazy segment tree sequencer for range assign and range sum
// One command word is taken at a time and gives one result word. The tree
// lives in one node memory (sum, pending mark, pending value) with a single
// read and a single write per cycle; a sequencer walks the tree with a small
// frame stack. Each visited node is read, then evaluated; a pending
// assignment is pushed down by writing the left child, the right child and
// then the node; an assign that covers a node writes it in a further state.
// An out-of-range or empty command is answered from idle without a walk.
// After each reset and length write the tree is cleared by marking the root.
module range_assign_range_sum_tree_unit (
	input logic      clk,
	input logic      arst_n,
	rars_cmd_if.sink   cmd,
	rars_rsp_if.source rsp,
	rars_cfg_if.sink   cfg
);

	typedef enum logic [11:0] {
		S_INIT   = 12'b000000000001,
		S_IDLE   = 12'b000000000010,
		S_CALL   = 12'b000000000100,
		S_EMPTY  = 12'b000000001000,
		S_EVAL   = 12'b000000010000,
		S_FULL   = 12'b000000100000,
		S_PUSH_L = 12'b000001000000,
		S_PUSH_R = 12'b000010000000,
		S_PUSH_P = 12'b000100000000,
		S_DESC   = 12'b001000000000,
		S_RET    = 12'b010000000000,
		S_FIN    = 12'b100000000000
	} state_t;

	state_t state_q;

	logic [rars_pkg::LEN_W-1:0]          len_q;
	logic                                op_q;
	logic signed [rars_pkg::VAL_W-1:0]   value_q;
	logic [rars_pkg::NODE_AW-1:0]        cur_v_q;
	logic [rars_pkg::IDX_W-1:0]          cur_lo_q, cur_hi_q, cur_l_q, cur_r_q;
	logic [rars_pkg::SP_W-1:0]           sp_q;
	logic signed [rars_pkg::SUM_W-1:0]   ret_q, nsum_q, prod_q;
	logic signed [rars_pkg::VAL_W-1:0]   pend_q;
	rars_pkg::frame_t                    stack_q [rars_pkg::STACK_DEPTH];
	logic                                out_valid_q, out_err_q;
	logic signed [rars_pkg::SUM_W-1:0]   out_sum_q;

	logic                                we, re;
	logic [rars_pkg::NODE_AW-1:0]        waddr;
	rars_pkg::node_t                     wdata, rdata;

	logic [rars_pkg::LEN_W-1:0]          eff_len;
	logic                                out_free, in_err, in_empty, out_load;
	logic [rars_pkg::SPAN_W-1:0]         mid_sum, t_mid_sum;
	logic [rars_pkg::IDX_W-1:0]          mid, t_mid;
	logic [rars_pkg::SPAN_W-1:0]         span, lspan, rspan, mul_b;
	logic signed [rars_pkg::VAL_W-1:0]   mul_a;
	logic signed [rars_pkg::PROD_W-1:0]  prod;
	logic                                full;
	logic [rars_pkg::TOP_W-1:0]          top_idx;
	rars_pkg::frame_t                    top;
	logic signed [rars_pkg::SUM_W-1:0]   total;

	assign eff_len  = (len_q > rars_pkg::LEN_W'(rars_pkg::LEAVES)) ?
	                  rars_pkg::LEN_W'(rars_pkg::LEAVES) : len_q;
	assign out_free = !out_valid_q || rsp.ready;
	assign in_err   = ({1'b0, cmd.range_low} >= eff_len) || ({1'b0, cmd.range_high} >= eff_len);
	assign in_empty = cmd.range_low > cmd.range_high;

	assign cmd.ready       = (state_q == S_IDLE) && out_free && !cfg.valid;
	assign cfg.ready       = (state_q == S_IDLE);
	assign rsp.valid       = out_valid_q;
	assign rsp.range_sum   = out_sum_q;
	assign rsp.range_error = out_err_q;

	assign out_load = ((state_q == S_IDLE) && cmd.valid && cmd.ready && (in_err || in_empty)) ||
	                  ((state_q == S_FIN) && out_free);

	assign mid_sum = {1'b0, cur_lo_q} + {1'b0, cur_hi_q};
	assign mid     = mid_sum[rars_pkg::SPAN_W-1:1];
	assign span    = {1'b0, cur_hi_q} - {1'b0, cur_lo_q} + rars_pkg::SPAN_W'(1);
	assign lspan   = {1'b0, mid} - {1'b0, cur_lo_q} + rars_pkg::SPAN_W'(1);
	assign rspan   = {1'b0, cur_hi_q} - {1'b0, mid};
	assign full    = (cur_l_q == cur_lo_q) && (cur_r_q == cur_hi_q);

	assign top_idx   = rars_pkg::TOP_W'(sp_q - rars_pkg::SP_W'(1));
	assign top       = stack_q[top_idx];
	assign t_mid_sum = {1'b0, top.lo} + {1'b0, top.hi};
	assign t_mid     = t_mid_sum[rars_pkg::SPAN_W-1:1];
	assign total     = top.acc + ret_q;

	always_comb begin
		mul_a = value_q;
		mul_b = span;
		case (state_q)
			S_EVAL: begin
				if (!full) begin
					mul_a = rdata.val;
					mul_b = lspan;
				end
			end
			S_PUSH_L: begin
				mul_a = pend_q;
				mul_b = rspan;
			end
			default: begin
			end
		endcase
	end

	assign prod = rars_pkg::PROD_W'(mul_a) * rars_pkg::PROD_W'($signed({1'b0, mul_b}));

	always_comb begin
		we    = 1'b0;
		waddr = cur_v_q;
		wdata = '{sum: prod_q, mark: 1'b1, val: pend_q};
		re    = (state_q == S_CALL);
		case (state_q)
			S_INIT: begin
				we    = 1'b1;
				waddr = rars_pkg::ROOT_NODE;
				wdata = '{sum: '0, mark: 1'b1, val: '0};
			end
			S_FULL: begin
				we    = 1'b1;
				wdata = '{sum: prod_q, mark: 1'b1, val: value_q};
			end
			S_PUSH_L: begin
				we    = 1'b1;
				waddr = {cur_v_q[rars_pkg::NODE_AW-2:0], 1'b0};
			end
			S_PUSH_R: begin
				we    = 1'b1;
				waddr = {cur_v_q[rars_pkg::NODE_AW-2:0], 1'b1};
			end
			S_PUSH_P: begin
				we    = 1'b1;
				wdata = '{sum: nsum_q, mark: 1'b0, val: pend_q};
			end
			S_RET: begin
				we    = (sp_q != '0) && top.right && (op_q == rars_pkg::OP_ASSIGN);
				waddr = top.v;
				wdata = '{sum: total, mark: 1'b0, val: '0};
			end
			default: begin
			end
		endcase
	end

	rars_ram #(
		.WIDTH ($bits(rars_pkg::node_t)),
		.DEPTH (rars_pkg::NODE_DEPTH)
	) u_node_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (cur_v_q),
		.rdata (rdata)
	);

	always_ff @(posedge clk) begin
		prod_q <= rars_pkg::SUM_W'(prod);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			len_q       <= rars_pkg::LEN_W'(rars_pkg::LEAVES);
			sp_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg.valid && cfg.ready) begin
				len_q   <= cfg.data;
				state_q <= S_INIT;
			end else begin
				case (state_q)
					S_INIT: begin
						state_q <= S_IDLE;
					end
					S_IDLE: begin
						if (cmd.valid && cmd.ready) begin
							op_q    <= cmd.operation;
							value_q <= cmd.value;
							if (in_err || in_empty) begin
								out_sum_q <= '0;
								out_err_q <= in_err;
							end else begin
								cur_v_q  <= rars_pkg::ROOT_NODE;
								cur_lo_q <= '0;
								cur_hi_q <= rars_pkg::IDX_W'(eff_len - rars_pkg::LEN_W'(1));
								cur_l_q  <= cmd.range_low;
								cur_r_q  <= cmd.range_high;
								sp_q     <= '0;
								state_q  <= S_CALL;
							end
						end
					end
					S_CALL: begin
						if (cur_l_q > cur_r_q) begin
							if (op_q == rars_pkg::OP_QUERY) begin
								ret_q   <= '0;
								state_q <= S_RET;
							end else begin
								state_q <= S_EMPTY;
							end
						end else begin
							state_q <= S_EVAL;
						end
					end
					S_EMPTY: begin
						ret_q   <= rdata.sum;
						state_q <= S_RET;
					end
					S_EVAL: begin
						nsum_q <= rdata.sum;
						pend_q <= rdata.val;
						if (full) begin
							if (op_q == rars_pkg::OP_QUERY) begin
								ret_q   <= rdata.sum;
								state_q <= S_RET;
							end else begin
								state_q <= S_FULL;
							end
						end else if (rdata.mark) begin
							state_q <= S_PUSH_L;
						end else begin
							state_q <= S_DESC;
						end
					end
					S_FULL: begin
						ret_q   <= prod_q;
						state_q <= S_RET;
					end
					S_PUSH_L: begin
						state_q <= S_PUSH_R;
					end
					S_PUSH_R: begin
						state_q <= S_PUSH_P;
					end
					S_PUSH_P: begin
						state_q <= S_DESC;
					end
					S_DESC: begin
						stack_q[rars_pkg::TOP_W'(sp_q)] <= '{v: cur_v_q, lo: cur_lo_q,
							hi: cur_hi_q, l: cur_l_q, r: cur_r_q, right: 1'b0, acc: '0};
						sp_q     <= sp_q + rars_pkg::SP_W'(1);
						cur_v_q  <= {cur_v_q[rars_pkg::NODE_AW-2:0], 1'b0};
						cur_hi_q <= mid;
						cur_r_q  <= (cur_r_q < mid) ? cur_r_q : mid;
						state_q  <= S_CALL;
					end
					S_RET: begin
						if (sp_q == '0) begin
							state_q <= S_FIN;
						end else if (!top.right) begin
							stack_q[top_idx].right <= 1'b1;
							stack_q[top_idx].acc   <= ret_q;
							cur_v_q  <= {top.v[rars_pkg::NODE_AW-2:0], 1'b1};
							cur_lo_q <= t_mid + rars_pkg::IDX_W'(1);
							cur_hi_q <= top.hi;
							cur_l_q  <= (top.l > t_mid + rars_pkg::IDX_W'(1)) ?
							            top.l : t_mid + rars_pkg::IDX_W'(1);
							cur_r_q  <= top.r;
							state_q  <= S_CALL;
						end else begin
							ret_q <= total;
							sp_q  <= sp_q - rars_pkg::SP_W'(1);
						end
					end
					S_FIN: begin
						if (out_free) begin
							out_sum_q <= (op_q == rars_pkg::OP_QUERY) ? ret_q : '0;
							out_err_q <= 1'b0;
							state_q   <= S_IDLE;
						end
					end
					default: begin
						state_q <= S_INIT;
					end
				endcase
			end
		end
	end

endmodule

@@ tb/tb_top.sv @@
// testbench for the range assign / range sum tree: directed table, then random words
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		int                                len;
		logic                              op;
		logic [rars_pkg::IDX_W-1:0]        lo;
		logic [rars_pkg::IDX_W-1:0]        hi;
		logic signed [rars_pkg::VAL_W-1:0] val;
		bit                                typed;
		logic signed [rars_pkg::SUM_W-1:0] sum;
		logic                              err;
	} row_t;

	typedef struct {
		logic signed [rars_pkg::SUM_W-1:0] sum;
		logic                              err;
	} result_t;

	localparam int CYCLE_LIMIT = 4000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	rars_cmd_if cmd_ch ();
	rars_rsp_if rsp_ch ();
	rars_cfg_if cfg_ch ();

	range_assign_range_sum_tree_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_ch.sink),
		.rsp(rsp_ch.source),
		.cfg(cfg_ch.sink)
	);

	logic signed [rars_pkg::VAL_W-1:0] array_vals [rars_pkg::LEAVES];
	int                      cur_len;
	result_t                 pending_results[$];
	bit                      cur_typed;
	result_t                 cur_typed_res;
	int                      errors;
	int                      cycles;
	bit                      gaps_on;
	bit                      stalls_on;
	bit                      long_hold;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		cmd_ch.valid = 1'b0;
		cmd_ch.operation = rars_pkg::OP_ASSIGN;
		cmd_ch.range_low = '0;
		cmd_ch.range_high = '0;
		cmd_ch.value = '0;
		rsp_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
	end

	function automatic result_t predict_word(logic op, int lo, int hi,
		logic signed [rars_pkg::VAL_W-1:0] v);
		result_t res;
		int      n;
		longint  acc;
		n = (cur_len > rars_pkg::LEAVES) ? rars_pkg::LEAVES : cur_len;
		res.sum = '0;
		res.err = 1'b0;
		acc = 0;
		if (lo >= n || hi >= n) begin
			res.err = 1'b1;
		end else if (lo <= hi) begin
			for (int i = lo; i <= hi; i++) begin
				if (op == rars_pkg::OP_ASSIGN)
					array_vals[i] = v;
				else
					acc += longint'(array_vals[i]);
			end
			if (op == rars_pkg::OP_QUERY)
				res.sum = acc[rars_pkg::SUM_W-1:0];
		end
		return res;
	endfunction

	always @(posedge clk) begin
		result_t exp_res;
		result_t got;
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_top failed");
			$finish;
		end
		if (cmd_ch.valid && cmd_ch.ready) begin
			exp_res = predict_word(cmd_ch.operation, cmd_ch.range_low, cmd_ch.range_high,
				cmd_ch.value);
			if (cur_typed)
				exp_res = cur_typed_res;
			pending_results = {pending_results, exp_res};
		end
		if (rsp_ch.valid && rsp_ch.ready) begin
			got.sum = rsp_ch.range_sum;
			got.err = rsp_ch.range_error;
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t unexpected word sum=%0d err=%0b", $time, got.sum, got.err);
			end else begin
				exp_res = pending_results.pop_front();
				if (got.sum !== exp_res.sum) begin
					errors++;
					$display("%0t range_sum expected %0d actual %0d", $time, exp_res.sum, got.sum);
				end
				if (got.err !== exp_res.err) begin
					errors++;
					$display("%0t range_error expected %0b actual %0b", $time, exp_res.err,
						got.err);
				end
			end
		end
	end

	// receiver: random stalls, one long hold-off
	always @(negedge clk) begin
		int hold_cnt;
		if (long_hold && hold_cnt == 0) begin
			hold_cnt = 600;
			long_hold = 1'b0;
		end
		if (hold_cnt > 0) begin
			hold_cnt--;
			rsp_ch.ready <= 1'b0;
		end else if (stalls_on) begin
			rsp_ch.ready <= ($urandom_range(0, 3) != 0);
		end else begin
			rsp_ch.ready <= 1'b1;
		end
	end

	task automatic wait_idle();
		cmd_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);
	endtask

	task automatic write_len(int len);
		wait_idle();
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= rars_pkg::LEN_W'(len);
		do
			@(posedge clk);
		while (!(cfg_ch.valid && cfg_ch.ready));
		cur_len = len;
		for (int i = 0; i < rars_pkg::LEAVES; i++)
			array_vals[i] = '0;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic send_word(logic op, logic [rars_pkg::IDX_W-1:0] lo,
		logic [rars_pkg::IDX_W-1:0] hi, logic signed [rars_pkg::VAL_W-1:0] v, bit typed,
		result_t tres, int gap);
		cmd_ch.valid <= 1'b1;
		cmd_ch.operation <= op;
		cmd_ch.range_low <= lo;
		cmd_ch.range_high <= hi;
		cmd_ch.value <= v;
		cur_typed <= typed;
		cur_typed_res <= tres;
		do
			@(posedge clk);
		while (!(cmd_ch.valid && cmd_ch.ready));
		@(negedge clk);
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	function automatic logic signed [rars_pkg::VAL_W-1:0] pick_value();
		case ($urandom_range(0, 5))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return 32'(signed'($urandom_range(0, 20)) - 10);
			default: return $urandom();
		endcase
	endfunction

	task automatic random_phase(int len, int count);
		int      n;
		int      lo;
		int      hi;
		int      burst;
		int      gap;
		int      t;
		result_t none;
		none = '{sum: '0, err: 1'b0};
		if (len != cur_len)
			write_len(len);
		n = (len > rars_pkg::LEAVES) ? rars_pkg::LEAVES : len;
		burst = 0;
		for (int k = 0; k < count; k++) begin
			if (n == 0 || $urandom_range(0, 9) == 0) begin
				lo = $urandom_range(0, rars_pkg::LEAVES - 1);
				hi = $urandom_range(0, rars_pkg::LEAVES - 1);
			end else begin
				lo = $urandom_range(0, n - 1);
				hi = $urandom_range(0, n - 1);
				if (lo > hi && $urandom_range(0, 7) != 0) begin
					t = lo;
					lo = hi;
					hi = t;
				end
			end
			if (burst == 0) begin
				burst = $urandom_range(1, 12);
				gap = gaps_on ? $urandom_range(0, 8) : 0;
			end else begin
				gap = 0;
			end
			burst--;
			if (burst != 0)
				gap = 0;
			send_word(logic'($urandom_range(0, 1)), lo[rars_pkg::IDX_W-1:0],
				hi[rars_pkg::IDX_W-1:0], pick_value(), 1'b0, none, gap);
		end
	endtask

	row_t table_rows[] = '{
		'{1024, rars_pkg::OP_QUERY, 10'd0, 10'd1023, 32'sd0, 1, 48'sd0, 0},
		'{1024, rars_pkg::OP_ASSIGN, 10'd0, 10'd1023, 32'sh7fffffff, 1, 48'sd0, 0},
		'{1024, rars_pkg::OP_QUERY, 10'd0, 10'd1023, 32'sd0, 1, 48'sd2199023254528, 0},
		'{1024, rars_pkg::OP_ASSIGN, 10'd0, 10'd1023, 32'sh80000000, 1, 48'sd0, 0},
		'{1024, rars_pkg::OP_QUERY, 10'd0, 10'd1023, 32'sd0, 1, -48'sd2199023255552, 0},
		'{1024, rars_pkg::OP_ASSIGN, 10'd5, 10'd3, 32'sd77, 1, 48'sd0, 0},
		'{1024, rars_pkg::OP_QUERY, 10'd7, 10'd2, 32'sd0, 1, 48'sd0, 0},
		'{1024, rars_pkg::OP_ASSIGN, 10'd1023, 10'd1023, 32'sd12, 1, 48'sd0, 0},
		'{1024, rars_pkg::OP_QUERY, 10'd1023, 10'd1023, 32'sd0, 1, 48'sd12, 0},
		'{1024, rars_pkg::OP_ASSIGN, 10'd100, 10'd611, 32'sd3, 0, 48'sd0, 0},
		'{1024, rars_pkg::OP_QUERY, 10'd0, 10'd1023, 32'sd0, 0, 48'sd0, 0},
		'{1024, rars_pkg::OP_QUERY, 10'd99, 10'd612, 32'sd0, 0, 48'sd0, 0},
		'{5, rars_pkg::OP_QUERY, 10'd0, 10'd4, 32'sd0, 1, 48'sd0, 0},
		'{5, rars_pkg::OP_QUERY, 10'd5, 10'd0, 32'sd0, 1, 48'sd0, 1},
		'{5, rars_pkg::OP_ASSIGN, 10'd0, 10'd5, 32'sd1, 1, 48'sd0, 1},
		'{5, rars_pkg::OP_QUERY, 10'd4, 10'd4, 32'sd0, 1, 48'sd0, 0},
		'{0, rars_pkg::OP_QUERY, 10'd0, 10'd0, 32'sd0, 1, 48'sd0, 1},
		'{0, rars_pkg::OP_ASSIGN, 10'd0, 10'd0, 32'sd4, 1, 48'sd0, 1},
		'{2047, rars_pkg::OP_QUERY, 10'd1023, 10'd1023, 32'sd0, 1, 48'sd0, 0},
		'{1, rars_pkg::OP_ASSIGN, 10'd0, 10'd0, 32'sd9, 1, 48'sd0, 0},
		'{1, rars_pkg::OP_QUERY, 10'd0, 10'd0, 32'sd0, 1, 48'sd9, 0},
		'{1, rars_pkg::OP_QUERY, 10'd1, 10'd0, 32'sd0, 1, 48'sd0, 1}
	};

	initial begin
		result_t tres;
		errors = 0;
		cycles = 0;
		cur_len = 1024;
		gaps_on = 1'b0;
		stalls_on = 1'b0;
		long_hold = 1'b0;
		for (int i = 0; i < rars_pkg::LEAVES; i++)
			array_vals[i] = '0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		foreach (table_rows[i]) begin
			if (table_rows[i].len != cur_len)
				write_len(table_rows[i].len);
			tres.sum = table_rows[i].sum;
			tres.err = table_rows[i].err;
			send_word(table_rows[i].op, table_rows[i].lo, table_rows[i].hi,
				table_rows[i].val, table_rows[i].typed, tres, i % 3);
		end
		random_phase(1024, 250);
		gaps_on = 1'b1;
		random_phase(2, 120);
		stalls_on = 1'b1;
		random_phase(37, 200);
		long_hold = 1'b1;
		random_phase(1024, 300);
		gaps_on = 1'b0;
		random_phase(3, 120);
		gaps_on = 1'b1;
		random_phase(513, 250);
		stalls_on = 1'b0;
		random_phase(int'($urandom_range(1, 1024)), 200);
		stalls_on = 1'b1;
		random_phase(1536, 200);
		wait_idle();
		repeat (40) @(negedge clk);
		if (errors == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end
endmodule
